// ===== rtl/urt_pkg.sv =====
// Shared types and constants for the ultrasonic range tracker.
// No dependencies; imported by every module of the block.
package urt_pkg;

    localparam int CHANNELS   = 4;
    localparam int CH_W       = (CHANNELS > 1) ? $clog2(CHANNELS) : 1;
    localparam int DATA_W     = 16;
    localparam int MISS_W     = 8;
    localparam int CFG_IDX_W  = 3;
    localparam int DIV_STEPS  = 16;
    localparam int DIV_CNT_W  = $clog2(DIV_STEPS + 1);

    localparam logic [CFG_IDX_W-1:0] CFG_PROCESS_NOISE     = 3'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_MEASUREMENT_NOISE = 3'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_MAX_RANGE         = 3'd2;
    localparam logic [CFG_IDX_W-1:0] CFG_MAX_MISSES        = 3'd3;
    localparam logic [CFG_IDX_W-1:0] CFG_INITIAL_VARIANCE  = 3'd4;

    localparam logic [DATA_W-1:0] RST_PROCESS_NOISE     = 16'd26;
    localparam logic [DATA_W-1:0] RST_MEASUREMENT_NOISE = 16'd256;
    localparam logic [DATA_W-1:0] RST_MAX_RANGE         = 16'd1280;
    localparam logic [MISS_W-1:0] RST_MAX_MISSES        = 8'd3;
    localparam logic [DATA_W-1:0] RST_INITIAL_VARIANCE  = 16'd1280;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_GATE,
        ST_PRED,
        ST_DIV,
        ST_MUL_EST,
        ST_MUL_VAR,
        ST_WB,
        ST_DONE
    } t_state;

    typedef struct packed {
        logic              start;
        logic [DATA_W-1:0] num;
        logic [DATA_W:0]   den;
    } t_div_req;

endpackage

// ===== rtl/urt_gain_div.sv =====
// Iterative restoring divider for the Kalman gain: floor(num * 2^16 / den).
// One quotient bit per cycle, saturates to all ones. Uses urt_pkg.
module urt_gain_div (
    input  logic                    i_clk,
    input  logic                    i_rst_n,
    input  urt_pkg::t_div_req       i_req,
    output logic                    o_done,
    output logic [urt_pkg::DATA_W-1:0] o_quo
);
    import urt_pkg::*;

    logic                 r_busy;
    logic                 r_done;
    logic [DIV_CNT_W-1:0] r_cnt;
    logic [DATA_W:0]      r_rem;
    logic [DATA_W:0]      r_den;
    logic [DATA_W-1:0]    r_quo;
    logic                 r_zero;
    logic                 r_ovf;

    logic [DATA_W+1:0]    w_trial;
    logic [DATA_W+1:0]    w_diff;
    logic                 w_ge;

    assign w_trial = {r_rem, 1'b0};
    assign w_ge    = w_trial >= {1'b0, r_den};
    assign w_diff  = w_trial - {1'b0, r_den};

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
            r_cnt  <= '0;
        end else begin
            r_done <= 1'b0;
            if (i_req.start) begin
                r_busy <= 1'b1;
                r_cnt  <= DIV_CNT_W'(DIV_STEPS);
            end else if (r_busy) begin
                r_cnt <= r_cnt - 1'b1;
                if (r_cnt == DIV_CNT_W'(1)) begin
                    r_busy <= 1'b0;
                    r_done <= 1'b1;
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_req.start) begin
            r_rem  <= {1'b0, i_req.num};
            r_den  <= i_req.den;
            r_quo  <= '0;
            r_zero <= (i_req.den == '0);
            r_ovf  <= ({1'b0, i_req.num} >= i_req.den);
        end else if (r_busy) begin
            r_rem <= w_ge ? w_diff[DATA_W:0] : w_trial[DATA_W:0];
            r_quo <= {r_quo[DATA_W-2:0], w_ge};
        end
    end

    assign o_done = r_done;
    assign o_quo  = r_zero ? '0 : (r_ovf ? '1 : r_quo);

endmodule

// ===== rtl/urt_mul.sv =====
// Shared multiplier with registered, rounded Q16 result: (a * b + 2^15) >> 16.
// Used for both the estimate step and the variance update. Uses urt_pkg.
module urt_mul (
    input  logic                       i_clk,
    input  logic [urt_pkg::DATA_W:0]   i_a,
    input  logic [urt_pkg::DATA_W-1:0] i_b,
    output logic [urt_pkg::DATA_W-1:0] o_res
);
    import urt_pkg::*;

    logic [2*DATA_W:0]  w_prod;
    logic [2*DATA_W:0]  w_rnd;
    logic [DATA_W-1:0]  r_res;

    assign w_prod = {{DATA_W{1'b0}}, i_a} * {{(DATA_W+1){1'b0}}, i_b};
    assign w_rnd  = w_prod + {{(DATA_W+1){1'b0}}, 1'b1, {(DATA_W-1){1'b0}}};

    always_ff @(posedge i_clk) begin
        r_res <= w_rnd[2*DATA_W-1:DATA_W];
    end

    assign o_res = r_res;

endmodule

// ===== rtl/ultrasonic_range_tracker.sv =====
// Ultrasonic range tracker top level: track gating and scalar Kalman filter
// for four probes. Depends on urt_pkg, urt_gain_div and urt_mul.
//
// Usage:
//   Input channel (i_valid / o_stall) carries one frame of four readings,
//   i_probe_0..3, unsigned Q8.8. Output channel (o_valid / i_stall) returns
//   o_range_0..3, the filtered distances clamped to the range limit.
//   Channels are processed one after another by one sequencer that shares
//   the gain divider (one quotient bit per cycle) and one multiplier.
//   A channel that neither holds nor opens a track, or drops its track, is
//   gated only; any other channel also runs predict, the 16-step divider and
//   two multiplies. One frame is in work at a time and o_stall stays high
//   until its result is registered. The result register is loaded only when
//   it is empty or being taken, so a stall on the output holds the block in
//   its final step. The user writes configuration through i_cfg_wr_en /
//   i_cfg_index / i_cfg_data only while the block is idle; the block itself
//   does not enforce this. Unknown indexes are ignored.
//   Reset (i_rst_n low, synchronous) restores the register defaults and
//   clears every track, estimate, variance and miss count.
module ultrasonic_range_tracker (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  logic                          i_cfg_wr_en,
    input  logic [urt_pkg::CFG_IDX_W-1:0] i_cfg_index,
    input  logic [urt_pkg::DATA_W-1:0]    i_cfg_data,
    input  logic                          i_valid,
    output logic                          o_stall,
    input  logic [urt_pkg::DATA_W-1:0]    i_probe_0,
    input  logic [urt_pkg::DATA_W-1:0]    i_probe_1,
    input  logic [urt_pkg::DATA_W-1:0]    i_probe_2,
    input  logic [urt_pkg::DATA_W-1:0]    i_probe_3,
    output logic                          o_valid,
    input  logic                          i_stall,
    output logic [urt_pkg::DATA_W-1:0]    o_range_0,
    output logic [urt_pkg::DATA_W-1:0]    o_range_1,
    output logic [urt_pkg::DATA_W-1:0]    o_range_2,
    output logic [urt_pkg::DATA_W-1:0]    o_range_3
);
    import urt_pkg::*;

    // configuration
    logic [DATA_W-1:0] r_pn;
    logic [DATA_W-1:0] r_mn;
    logic [DATA_W-1:0] r_mr;
    logic [MISS_W-1:0] r_mm;
    logic [DATA_W-1:0] r_iv;

    // sequencer and per-channel state
    t_state            r_state, n_state;
    logic [CH_W-1:0]   r_ch, n_ch;
    logic              r_out_valid, n_out_valid;
    logic [DATA_W-1:0] r_est  [CHANNELS];
    logic [DATA_W-1:0] n_est  [CHANNELS];
    logic [DATA_W-1:0] r_var  [CHANNELS];
    logic [DATA_W-1:0] n_var  [CHANNELS];
    logic              r_trk  [CHANNELS];
    logic              n_trk  [CHANNELS];
    logic [MISS_W-1:0] r_miss [CHANNELS];
    logic [MISS_W-1:0] n_miss [CHANNELS];

    // working payload
    logic [DATA_W-1:0] r_probe [CHANNELS];
    logic [DATA_W-1:0] n_probe [CHANNELS];
    logic [DATA_W-1:0] r_out   [CHANNELS];
    logic [DATA_W-1:0] n_out   [CHANNELS];
    logic [DATA_W-1:0] r_z, n_z;
    logic [DATA_W-1:0] r_gain, n_gain;
    logic [DATA_W-1:0] r_var_p, n_var_p;
    logic              r_up, n_up;

    logic [DATA_W-1:0] w_probe [CHANNELS];
    logic [DATA_W-1:0] w_rd;
    logic              w_in_range;
    logic [MISS_W-1:0] w_miss_inc;
    logic [DATA_W:0]   w_var_sum;
    logic [DATA_W-1:0] w_var_sat;
    logic              w_up;
    logic [DATA_W-1:0] w_mag;
    logic              w_last;

    t_div_req          w_div_req;
    logic              w_div_done;
    logic [DATA_W-1:0] w_div_quo;
    logic [DATA_W:0]   w_mul_a;
    logic [DATA_W-1:0] w_mul_b;
    logic [DATA_W-1:0] w_mul_res;

    assign w_probe[0] = i_probe_0;
    assign w_probe[1] = i_probe_1;
    assign w_probe[2] = i_probe_2;
    assign w_probe[3] = i_probe_3;

    urt_gain_div u_div (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_req   (w_div_req),
        .o_done  (w_div_done),
        .o_quo   (w_div_quo)
    );

    urt_mul u_mul (
        .i_clk (i_clk),
        .i_a   (w_mul_a),
        .i_b   (w_mul_b),
        .o_res (w_mul_res)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_pn <= RST_PROCESS_NOISE;
            r_mn <= RST_MEASUREMENT_NOISE;
            r_mr <= RST_MAX_RANGE;
            r_mm <= RST_MAX_MISSES;
            r_iv <= RST_INITIAL_VARIANCE;
        end else if (i_cfg_wr_en) begin
            case (i_cfg_index)
                CFG_PROCESS_NOISE:     r_pn <= i_cfg_data;
                CFG_MEASUREMENT_NOISE: r_mn <= i_cfg_data;
                CFG_MAX_RANGE:         r_mr <= i_cfg_data;
                CFG_MAX_MISSES:        r_mm <= i_cfg_data[MISS_W-1:0];
                CFG_INITIAL_VARIANCE:  r_iv <= i_cfg_data;
                default: ;
            endcase
        end
    end

    assign w_rd       = r_probe[r_ch];
    assign w_in_range = w_rd < r_mr;
    assign w_miss_inc = (r_miss[r_ch] == '1) ? r_miss[r_ch] : r_miss[r_ch] + 1'b1;
    assign w_var_sum  = {1'b0, r_var[r_ch]} + {1'b0, r_pn};
    assign w_var_sat  = w_var_sum[DATA_W] ? '1 : w_var_sum[DATA_W-1:0];
    assign w_up       = r_z >= r_est[r_ch];
    assign w_mag      = w_up ? (r_z - r_est[r_ch]) : (r_est[r_ch] - r_z);
    assign w_last     = r_ch == CH_W'(CHANNELS - 1);

    always_comb begin
        n_state     = r_state;
        n_ch        = r_ch;
        n_out_valid = r_out_valid;
        n_est       = r_est;
        n_var       = r_var;
        n_trk       = r_trk;
        n_miss      = r_miss;
        n_probe     = r_probe;
        n_out       = r_out;
        n_z         = r_z;
        n_gain      = r_gain;
        n_var_p     = r_var_p;
        n_up        = r_up;
        w_div_req.start = 1'b0;
        w_div_req.num   = w_var_sat;
        w_div_req.den   = {1'b0, w_var_sat} + {1'b0, r_mn};
        w_mul_a     = {1'b0, r_gain};
        w_mul_b     = w_mag;

        if (r_out_valid && !i_stall) begin
            n_out_valid = 1'b0;
        end

        case (r_state)
            ST_IDLE: begin
                if (i_valid) begin
                    n_probe = w_probe;
                    n_ch    = '0;
                    n_state = ST_GATE;
                end
            end
            ST_GATE: begin
                n_state = ST_PRED;
                n_z     = w_rd;
                if (r_trk[r_ch]) begin
                    if (w_in_range) begin
                        n_miss[r_ch] = '0;
                    end else if (w_miss_inc >= r_mm) begin
                        n_est[r_ch]  = r_mr;
                        n_trk[r_ch]  = 1'b0;
                        n_miss[r_ch] = '0;
                        n_state      = w_last ? ST_DONE : ST_GATE;
                        n_ch         = w_last ? r_ch : r_ch + 1'b1;
                    end else begin
                        n_miss[r_ch] = w_miss_inc;
                        n_z          = r_est[r_ch];
                    end
                end else if (w_in_range) begin
                    n_trk[r_ch] = 1'b1;
                    n_est[r_ch] = w_rd;
                    n_var[r_ch] = r_iv;
                end else begin
                    n_est[r_ch] = r_mr;
                    n_state     = w_last ? ST_DONE : ST_GATE;
                    n_ch        = w_last ? r_ch : r_ch + 1'b1;
                end
            end
            ST_PRED: begin
                w_div_req.start = 1'b1;
                n_var_p         = w_var_sat;
                n_state         = ST_DIV;
            end
            ST_DIV: begin
                if (w_div_done) begin
                    n_gain  = w_div_quo;
                    n_state = ST_MUL_EST;
                end
            end
            ST_MUL_EST: begin
                n_up    = w_up;
                n_state = ST_MUL_VAR;
            end
            ST_MUL_VAR: begin
                w_mul_a     = {1'b1, {DATA_W{1'b0}}} - {1'b0, r_gain};
                w_mul_b     = r_var_p;
                n_est[r_ch] = r_up ? r_est[r_ch] + w_mul_res : r_est[r_ch] - w_mul_res;
                n_state     = ST_WB;
            end
            ST_WB: begin
                n_var[r_ch] = w_mul_res;
                n_state     = w_last ? ST_DONE : ST_GATE;
                n_ch        = w_last ? r_ch : r_ch + 1'b1;
            end
            ST_DONE: begin
                if (!r_out_valid || !i_stall) begin
                    for (int k = 0; k < CHANNELS; k++) begin
                        n_out[k] = (r_est[k] > r_mr) ? r_mr : r_est[k];
                    end
                    n_out_valid = 1'b1;
                    n_state     = ST_IDLE;
                end
            end
            default: begin
                n_state = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= ST_IDLE;
            r_ch        <= '0;
            r_out_valid <= 1'b0;
            for (int k = 0; k < CHANNELS; k++) begin
                r_est[k]  <= '0;
                r_var[k]  <= '0;
                r_trk[k]  <= 1'b0;
                r_miss[k] <= '0;
            end
        end else begin
            r_state     <= n_state;
            r_ch        <= n_ch;
            r_out_valid <= n_out_valid;
            r_est       <= n_est;
            r_var       <= n_var;
            r_trk       <= n_trk;
            r_miss      <= n_miss;
        end
    end

    always_ff @(posedge i_clk) begin
        r_probe <= n_probe;
        r_out   <= n_out;
        r_z     <= n_z;
        r_gain  <= n_gain;
        r_var_p <= n_var_p;
        r_up    <= n_up;
    end

    assign o_stall   = r_state != ST_IDLE;
    assign o_valid   = r_out_valid;
    assign o_range_0 = r_out[0];
    assign o_range_1 = r_out[1];
    assign o_range_2 = r_out[2];
    assign o_range_3 = r_out[3];

    a_div_in_div_state: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_div_done |-> r_state == ST_DIV)
        else $error("divider finished outside its wait state");

    a_accept_starts_frame: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_valid && !o_stall) |=> (r_state == ST_GATE && r_ch == '0))
        else $error("accepted transaction did not start at channel zero");

    a_result_from_done: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $rose(o_valid) |-> $past(r_state) == ST_DONE)
        else $error("result raised outside the final step");

endmodule
